[hw/rtl/csi_pkg.sv]
package csi_pkg;

    localparam int VAL_W     = 32;
    localparam int CFG_W     = 32;
    localparam int RANGE_W   = 13;
    localparam int SLOT_W    = 12;
    localparam int CNT_W     = 17;
    localparam int POS_W     = 16;
    localparam int RAM_DEPTH = 4096;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [RANGE_W-1:0] RANGE_MAX   = 13'd4096;
    localparam logic [RANGE_W-1:0] RANGE_RESET = 13'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_VALUE  = 2'd0,
        CFG_RANGE      = 2'd1,
        CFG_DESCENDING = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        CMD_COUNT = 1'b0,
        CMD_PLACE = 1'b1
    } cmd_t;

    // one classified word from the front to the back
    typedef struct packed {
        logic               place;
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic               last;
        logic [POS_W-1:0]   src;
        logic               err;
        logic [RANGE_W-1:0] rng;
        logic               desc;
    } csi_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } csi_q_stat_t;

    typedef struct packed {
        logic sweeping;
    } csi_back_stat_t;

    typedef enum logic [2:0] {
        ST_RUN    = 3'b001,
        ST_PREFIX = 3'b010,
        ST_CLEAR  = 3'b100
    } csi_state_t;

endpackage

[hw/rtl/csi_ram.sv]
module csi_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/csi_front.sv]
module csi_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          cmd,
    input  logic [csi_pkg::VAL_W-1:0]     value,
    input  logic                          is_null,
    input  logic                          last,
    input  logic                          cfg_we,
    input  logic [csi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [csi_pkg::CFG_W-1:0]     cfg_data,
    input  csi_pkg::csi_q_stat_t          q_stat,
    output logic                          push,
    output csi_pkg::csi_entry_t           entry
);

    logic [csi_pkg::VAL_W-1:0]   min_reg;
    logic [csi_pkg::RANGE_W-1:0] range_reg;
    logic                        desc_reg;
    logic                        err_reg;
    logic                        err_next;
    logic [csi_pkg::POS_W-1:0]   cnt_reg;
    logic [csi_pkg::POS_W-1:0]   cnt_next;
    logic [csi_pkg::RANGE_W-1:0] rng_eff;
    logic [csi_pkg::VAL_W:0]     diff;
    logic                        hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= '0;
            range_reg <= csi_pkg::RANGE_RESET;
            desc_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                csi_pkg::CFG_MIN_VALUE:  min_reg   <= cfg_data;
                csi_pkg::CFG_RANGE:      range_reg <= cfg_data[csi_pkg::RANGE_W-1:0];
                csi_pkg::CFG_DESCENDING: desc_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (range_reg == '0)
            rng_eff = {{(csi_pkg::RANGE_W-1){1'b0}}, 1'b1};
        else if (range_reg > csi_pkg::RANGE_MAX)
            rng_eff = csi_pkg::RANGE_MAX;
        else
            rng_eff = range_reg;
    end

    // 33-bit signed offset from min_value
    assign diff = {value[csi_pkg::VAL_W-1], value} - {min_reg[csi_pkg::VAL_W-1], min_reg};
    assign hit  = !is_null && !diff[csi_pkg::VAL_W]
                  && (diff[csi_pkg::VAL_W-1:0]
                      < {{(csi_pkg::VAL_W-csi_pkg::RANGE_W){1'b0}}, rng_eff});

    assign push     = start && !q_stat.full;
    assign err_next = err_reg || (!is_null && !hit);
    assign cnt_next = last ? '0 : cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (push)
        begin
            err_reg <= err_next;
            cnt_reg <= cnt_next;
        end
    end

    always_comb
    begin
        entry.place = (cmd == csi_pkg::CMD_PLACE);
        entry.hit   = hit;
        entry.slot  = diff[csi_pkg::SLOT_W-1:0];
        entry.last  = last;
        entry.src   = cnt_reg;
        entry.err   = err_next;
        entry.rng   = rng_eff;
        entry.desc  = desc_reg;
    end

endmodule

[hw/rtl/csi_queue.sv]
module csi_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  csi_pkg::csi_entry_t  din,
    input  logic                 pop,
    output csi_pkg::csi_entry_t  head,
    output csi_pkg::csi_q_stat_t stat
);

    csi_pkg::csi_entry_t         mem_reg [csi_pkg::QDEPTH];
    logic [csi_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [csi_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [csi_pkg::QPTR_W:0]    count_reg;
    logic [csi_pkg::QPTR_W:0]    count_next;

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == (csi_pkg::QPTR_W+1)'(csi_pkg::QDEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

[hw/rtl/csi_back.sv]
module csi_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  csi_pkg::csi_entry_t         head,
    input  csi_pkg::csi_q_stat_t        q_stat,
    output logic                        pop,
    output logic                        result_valid,
    output logic [csi_pkg::POS_W-1:0]   dest_position,
    output logic [csi_pkg::POS_W-1:0]   source_index,
    output logic                        range_error,
    output logic                        end_of_run,
    output csi_pkg::csi_back_stat_t     stat
);

    csi_pkg::csi_state_t         state_reg, state_next;
    logic                        ex_valid_reg;
    csi_pkg::csi_entry_t         ex_reg;
    logic                        fwd_valid_reg;
    logic [csi_pkg::SLOT_W-1:0]  fwd_addr_reg;
    logic [csi_pkg::CNT_W-1:0]   fwd_data_reg;
    logic [csi_pkg::CNT_W-1:0]   null_reg, null_next;
    logic [csi_pkg::SLOT_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [csi_pkg::RANGE_W-1:0] pf_cnt_reg, pf_cnt_next;
    logic [csi_pkg::RANGE_W-1:0] pf_rng_reg, pf_rng_next;
    logic                        pf_desc_reg, pf_desc_next;
    logic                        pf_pend_reg, pf_pend_next;
    logic [csi_pkg::SLOT_W-1:0]  pf_addr_reg, pf_addr_next;
    logic [csi_pkg::CNT_W-1:0]   sum_reg, sum_next;
    logic                        res_valid_reg, res_valid_next;
    logic [csi_pkg::POS_W-1:0]   dest_reg, dest_next;
    logic [csi_pkg::POS_W-1:0]   src_reg, src_next;
    logic                        err_reg, err_next;
    logic                        eor_reg, eor_next;

    logic                        ram_we;
    logic [csi_pkg::SLOT_W-1:0]  ram_waddr;
    logic [csi_pkg::CNT_W-1:0]   ram_wdata;
    logic [csi_pkg::SLOT_W-1:0]  ram_raddr;
    logic [csi_pkg::CNT_W-1:0]   ram_rdata;
    logic [csi_pkg::CNT_W-1:0]   cnt_cur;
    logic [csi_pkg::RANGE_W-1:0] pf_down;
    logic                        pf_issue;

    csi_ram #(
        .WIDTH (csi_pkg::CNT_W),
        .DEPTH (csi_pkg::RAM_DEPTH)
    ) u_buckets (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // no pop behind a last word: it turns into a sweep
    assign pop = (state_reg == csi_pkg::ST_RUN) && !q_stat.empty
                 && !(ex_valid_reg && ex_reg.last);

    // RAM reads old data on a same-edge write, so bypass the previous write
    assign cnt_cur = (fwd_valid_reg && (fwd_addr_reg == ex_reg.slot)) ? fwd_data_reg
                                                                       : ram_rdata;

    assign pf_issue = (pf_cnt_reg < pf_rng_reg);
    assign pf_down  = pf_rng_reg - pf_cnt_reg - 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        null_next      = null_reg;
        clr_cnt_next   = clr_cnt_reg;
        pf_cnt_next    = pf_cnt_reg;
        pf_rng_next    = pf_rng_reg;
        pf_desc_next   = pf_desc_reg;
        pf_pend_next   = 1'b0;
        pf_addr_next   = pf_addr_reg;
        sum_next       = sum_reg;
        res_valid_next = 1'b0;
        dest_next      = dest_reg;
        src_next       = src_reg;
        err_next       = err_reg;
        eor_next       = eor_reg;
        ram_we         = 1'b0;
        ram_waddr      = ex_reg.slot;
        ram_wdata      = cnt_cur + 1'b1;
        ram_raddr      = head.slot;

        case (state_reg)
            csi_pkg::ST_RUN:
            begin
                if (ex_valid_reg)
                begin
                    if (ex_reg.hit)
                        ram_we = 1'b1;
                    if (ex_reg.place)
                    begin
                        res_valid_next = 1'b1;
                        src_next       = ex_reg.src;
                        err_next       = ex_reg.err;
                        eor_next       = ex_reg.last;
                        if (ex_reg.hit)
                            dest_next = cnt_cur[csi_pkg::POS_W-1:0];
                        else
                        begin
                            dest_next = null_reg[csi_pkg::POS_W-1:0];
                            null_next = null_reg + 1'b1;
                        end
                    end
                    if (ex_reg.last)
                    begin
                        if (ex_reg.place)
                        begin
                            null_next    = '0;
                            clr_cnt_next = '0;
                            state_next   = csi_pkg::ST_CLEAR;
                        end
                        else
                        begin
                            pf_cnt_next  = '0;
                            pf_rng_next  = ex_reg.rng;
                            pf_desc_next = ex_reg.desc;
                            sum_next     = '0;
                            state_next   = csi_pkg::ST_PREFIX;
                        end
                    end
                end
            end

            csi_pkg::ST_PREFIX:
            begin
                ram_raddr = pf_desc_reg ? pf_down[csi_pkg::SLOT_W-1:0]
                                        : pf_cnt_reg[csi_pkg::SLOT_W-1:0];
                if (pf_issue)
                begin
                    pf_cnt_next  = pf_cnt_reg + 1'b1;
                    pf_pend_next = 1'b1;
                    pf_addr_next = ram_raddr;
                end
                // exclusive prefix: store the running sum, then add the count
                if (pf_pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pf_addr_reg;
                    ram_wdata = sum_reg;
                    sum_next  = sum_reg + ram_rdata;
                end
                if (!pf_issue && !pf_pend_reg)
                begin
                    null_next  = sum_reg;
                    state_next = csi_pkg::ST_RUN;
                end
            end

            csi_pkg::ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                    state_next = csi_pkg::ST_RUN;
            end

            default:
            begin
                clr_cnt_next = '0;
                state_next   = csi_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= csi_pkg::ST_CLEAR;
            ex_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            null_reg      <= '0;
            clr_cnt_reg   <= '0;
            pf_pend_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ex_valid_reg  <= pop;
            fwd_valid_reg <= ram_we;
            null_reg      <= null_next;
            clr_cnt_reg   <= clr_cnt_next;
            pf_pend_reg   <= pf_pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            ex_reg <= head;
        fwd_addr_reg <= ram_waddr;
        fwd_data_reg <= ram_wdata;
        pf_cnt_reg   <= pf_cnt_next;
        pf_rng_reg   <= pf_rng_next;
        pf_desc_reg  <= pf_desc_next;
        pf_addr_reg  <= pf_addr_next;
        sum_reg      <= sum_next;
        dest_reg     <= dest_next;
        src_reg      <= src_next;
        err_reg      <= err_next;
        eor_reg      <= eor_next;
    end

    assign result_valid  = res_valid_reg;
    assign dest_position = dest_reg;
    assign source_index  = src_reg;
    assign range_error   = err_reg;
    assign end_of_run    = eor_reg;
    assign stat.sweeping = (state_reg != csi_pkg::ST_RUN);

endmodule

[hw/rtl/counting_sort_indices.sv]
// channel   direction  handshake              fields
// command   in         start, busy            cmd, value, is_null, last
// config    in         cfg_we                 cfg_index, cfg_data
// result    out        result_valid (1 cycle) dest_position, source_index, range_error, end_of_run
//
// Count and place words stream at one per cycle while busy is low, through a 4-word
// queue into the bucket RAM back end; with the queue empty and no sweep running, an
// accepted word passes the queue entry and the execute register before the result register.
// After the last count word the back end runs a prefix sweep of the effective range;
// after the last place word and after reset it clears the 4096-entry RAM.
// busy rises only when the queue is full, so words are taken during sweeps until then.
// The result port has no back-pressure.
module counting_sort_indices (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cmd,
    input  logic [csi_pkg::VAL_W-1:0]     value,
    input  logic                          is_null,
    input  logic                          last,
    input  logic                          cfg_we,
    input  logic [csi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [csi_pkg::CFG_W-1:0]     cfg_data,
    output logic                          result_valid,
    output logic [csi_pkg::POS_W-1:0]     dest_position,
    output logic [csi_pkg::POS_W-1:0]     source_index,
    output logic                          range_error,
    output logic                          end_of_run
);

    csi_pkg::csi_entry_t     q_din;
    csi_pkg::csi_entry_t     q_head;
    csi_pkg::csi_q_stat_t    q_stat;
    csi_pkg::csi_back_stat_t b_stat;
    logic                    q_push;
    logic                    q_pop;

    csi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .value     (value),
        .is_null   (is_null),
        .last      (last),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .push      (q_push),
        .entry     (q_din)
    );

    csi_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .head  (q_head),
        .stat  (q_stat)
    );

    csi_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (q_head),
        .q_stat        (q_stat),
        .pop           (q_pop),
        .result_valid  (result_valid),
        .dest_position (dest_position),
        .source_index  (source_index),
        .range_error   (range_error),
        .end_of_run    (end_of_run),
        .stat          (b_stat)
    );

    assign busy = q_stat.full;

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("back end popped an empty queue");

    a_quiet_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        b_stat.sweeping |=> !result_valid)
        else $error("result strobe following a sweep cycle");

    a_eor_starts_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && end_of_run) |-> b_stat.sweeping)
        else $error("end of run without bucket clear");

endmodule
